// File: sv/gcast_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcast_pkg
// shared constants, types and helpers of the grid ray caster
// ----------------------------------------------------------------------------
package gcast_pkg;

  localparam int MAP_SIZE  = 32;
  localparam int COLUMNS   = 160;
  localparam int ROWS      = 128;
  localparam int TEX_SIZE  = 16;
  localparam int MAX_STEPS = 64;

  localparam int MAP_W   = $clog2(MAP_SIZE);
  localparam int ADDR_W  = 2 * MAP_W;
  localparam int TEX_W   = $clog2(TEX_SIZE);
  localparam int STEP_W  = $clog2(MAX_STEPS + 1);
  localparam int POS_W   = 21;
  localparam int VEC_W   = 18;
  localparam int RAY_W   = 20;
  localparam int DIST_W  = 48;
  localparam int QUO_W   = 33;
  localparam int HGT_W   = 12;
  localparam int ROW_W   = 8;
  localparam int CODE_W  = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic [DIST_W-1:0] DIST_INF   = {DIST_W{1'b1}};
  localparam logic [POS_W-1:0]  PERP_MAX   = {POS_W{1'b1}};
  localparam logic [HGT_W-1:0]  HEIGHT_MAX = {HGT_W{1'b1}};
  localparam logic [QUO_W-1:0]  NUM_DELTA  = QUO_W'(64'd1 << 32);
  localparam logic [QUO_W-1:0]  NUM_HEIGHT = QUO_W'(64'(ROWS) << 16);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_POS_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y = 3'd5;

  typedef enum logic [1:0] {DIV_DX, DIV_DY, DIV_HT} div_sel_t;

  typedef struct packed {
    logic              map_clr;
    logic              map_wr;
    logic [ADDR_W-1:0] clr_addr;
    logic              cast_ld;
    logic              ray_ld;
    logic              div_start;
    div_sel_t          div_sel;
    logic              dx_ld;
    logic              dy_ld;
    logic              side_ld;
    logic              step;
    logic              code_ld;
    logic              h_ld;
    logic              tex_ld;
    logic              out_ld;
    logic              hit;
  } cmd_t;

  typedef struct packed {
    logic in_op;
    logic col_ok;
    logic div_done;
    logic oob;
    logic code_nz;
    logic out_full;
  } sts_t;

  // camera x in q.16: floor(col * 131072 / COLUMNS) - 65536, with
  // col * 4096 / 5 = 819 * col + col / 5 for the default column count
  function automatic logic signed [VEC_W-1:0] cam_of(input logic [7:0] col);
    logic [VEC_W-1:0] q;
    logic [17:0]      c5;
    c5 = (18'(col) * 18'd205) >> 10;
    q  = VEC_W'(18'(col) * 18'd819) + VEC_W'(c5);
    return $signed(q - VEC_W'(65536));
  endfunction

endpackage

// File: sv/gcast_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcast_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gcast_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [gcast_pkg::QUO_W-1:0]   num,
  input  logic [gcast_pkg::DIST_W-1:0]  den,
  output logic                          done,
  output logic [gcast_pkg::QUO_W-1:0]   quo
);
  import gcast_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [QUO_W-1:0]    num_r, num_nxt;
  logic [DIST_W-1:0]   den_r, den_nxt;
  logic [DIST_W-1:0]   rem_r, rem_nxt;
  logic [DIST_W:0]     trial;
  logic                ge;

  always_comb begin
    trial    = {rem_r, num_r[QUO_W-1]};
    ge       = trial >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(QUO_W);
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? DIST_W'(trial - {1'b0, den_r}) : DIST_W'(trial);
      num_nxt = {num_r[QUO_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

// File: sv/gcast_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcast_map
// wall code store, one write and one registered read port
// ----------------------------------------------------------------------------
module gcast_map (
  input  logic                          clk,
  input  logic                          we,
  input  logic [gcast_pkg::ADDR_W-1:0]  waddr,
  input  logic [gcast_pkg::CODE_W-1:0]  wdata,
  input  logic [gcast_pkg::ADDR_W-1:0]  raddr,
  output logic [gcast_pkg::CODE_W-1:0]  rdata
);
  import gcast_pkg::*;

  logic [CODE_W-1:0] mem [MAP_SIZE*MAP_SIZE];
  logic [CODE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/gcast_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcast_dp
// ray setup, dda walk registers, map store and result formatting
// ----------------------------------------------------------------------------
module gcast_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  gcast_pkg::cmd_t                  cmd,
  output gcast_pkg::sts_t                  sts,
  input  logic                             cfg_valid,
  input  logic [gcast_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcast_pkg::POS_W-1:0]      cfg_data,
  input  logic [23:0]                      in_tdata,
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [71:0]                      out_tdata,
  output logic                             out_tuser
);
  import gcast_pkg::*;

  logic [POS_W-1:0]        pos_x_r, pos_y_r;
  logic signed [VEC_W-1:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  logic [7:0]              col_r;
  logic signed [VEC_W-1:0] cam_r;
  logic signed [RAY_W-1:0] rx_r, ry_r;
  logic [DIST_W-1:0]       dx_r, dy_r, sx_r, sy_r, perp_r;
  logic signed [MAP_W+1:0] mx_r, my_r;
  logic                    side_r;
  logic [CODE_W-1:0]       code_r;
  logic [HGT_W-1:0]        h_r;
  logic [15:0]             wf_r;
  logic                    out_valid_r;
  logic [71:0]             out_data_r;
  logic                    out_hit_r;

  logic [7:0]              in_col;
  logic [MAP_W-1:0]        in_row, in_cc;
  logic [CODE_W-1:0]       in_code;

  logic signed [2*VEC_W-1:0] px, py;
  logic [RAY_W-2:0]          arx, ary;
  logic [QUO_W-1:0]          div_num, quo;
  logic [DIST_W-1:0]         div_den;
  logic                      div_done;
  logic [16:0]               fx, fy;
  logic [49:0]               mx_prod, my_prod;
  logic [DIST_W:0]           sx_sum, sy_sum;
  logic                      x_wins;
  logic [31:0]               tprod;
  logic [ADDR_W-1:0]         map_waddr, map_raddr;
  logic [CODE_W-1:0]         map_wdata, map_rdata;
  logic [TEX_W-1:0]          tex;
  logic [HGT_W-2:0]          h2;
  logic [ROW_W-1:0]          ds, de;
  logic [POS_W-1:0]          pd;

  assign in_col  = in_tdata[7:0];
  assign in_row  = in_tdata[8 +: MAP_W];
  assign in_cc   = in_tdata[13 +: MAP_W];
  assign in_code = in_tdata[18 +: CODE_W];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      dir_x_r   <= -VEC_W'(65536);
      dir_y_r   <= '0;
      plane_x_r <= '0;
      plane_y_r <= VEC_W'(43254);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POS_X:   pos_x_r   <= cfg_data;
        REG_POS_Y:   pos_y_r   <= cfg_data;
        REG_DIR_X:   dir_x_r   <= cfg_data[VEC_W-1:0];
        REG_DIR_Y:   dir_y_r   <= cfg_data[VEC_W-1:0];
        REG_PLANE_X: plane_x_r <= cfg_data[VEC_W-1:0];
        REG_PLANE_Y: plane_y_r <= cfg_data[VEC_W-1:0];
        default: ;
      endcase
    end
  end

  // ray setup
  assign px  = plane_x_r * cam_r;
  assign py  = plane_y_r * cam_r;
  assign arx = rx_r[RAY_W-1] ? (RAY_W-1)'(-rx_r) : rx_r[RAY_W-2:0];
  assign ary = ry_r[RAY_W-1] ? (RAY_W-1)'(-ry_r) : ry_r[RAY_W-2:0];

  always_comb begin
    case (cmd.div_sel)
      DIV_DX: begin
        div_num = NUM_DELTA;
        div_den = DIST_W'(arx);
      end
      DIV_DY: begin
        div_num = NUM_DELTA;
        div_den = DIST_W'(ary);
      end
      default: begin
        div_num = NUM_HEIGHT;
        div_den = perp_r;
      end
    endcase
  end

  gcast_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  // distance to the first grid line on each axis
  assign fx      = rx_r[RAY_W-1] ? {1'b0, pos_x_r[15:0]} : 17'h10000 - {1'b0, pos_x_r[15:0]};
  assign fy      = ry_r[RAY_W-1] ? {1'b0, pos_y_r[15:0]} : 17'h10000 - {1'b0, pos_y_r[15:0]};
  assign mx_prod = fx * dx_r[QUO_W-1:0];
  assign my_prod = fy * dy_r[QUO_W-1:0];

  assign sx_sum = {1'b0, sx_r} + {1'b0, dx_r};
  assign sy_sum = {1'b0, sy_r} + {1'b0, dy_r};
  assign x_wins = sx_r < sy_r;

  // low half of perp times ray is all the wall fraction needs
  assign tprod = side_r ? perp_r[31:0] * 32'(rx_r) : perp_r[31:0] * 32'(ry_r);

  always_ff @(posedge clk) begin
    if (cmd.cast_ld) begin
      col_r <= in_col;
      cam_r <= cam_of(in_col);
    end
    if (cmd.ray_ld) begin
      rx_r <= RAY_W'(dir_x_r) + RAY_W'(px >>> 16);
      ry_r <= RAY_W'(dir_y_r) + RAY_W'(py >>> 16);
    end
    if (cmd.dx_ld) begin
      dx_r <= (rx_r == '0) ? DIST_INF : DIST_W'(quo);
    end
    if (cmd.dy_ld) begin
      dy_r <= (ry_r == '0) ? DIST_INF : DIST_W'(quo);
    end
    if (cmd.side_ld) begin
      sx_r <= (dx_r == DIST_INF) ? DIST_INF : DIST_W'(mx_prod[49:16]);
      sy_r <= (dy_r == DIST_INF) ? DIST_INF : DIST_W'(my_prod[49:16]);
      mx_r <= (MAP_W+2)'(pos_x_r[POS_W-1:16]);
      my_r <= (MAP_W+2)'(pos_y_r[POS_W-1:16]);
    end
    if (cmd.step) begin
      if (x_wins) begin
        perp_r <= sx_r;
        sx_r   <= (sx_sum > {1'b0, DIST_INF}) ? DIST_INF : sx_sum[DIST_W-1:0];
        mx_r   <= rx_r[RAY_W-1] ? mx_r - 1'b1 : mx_r + 1'b1;
        side_r <= 1'b0;
      end else begin
        perp_r <= sy_r;
        sy_r   <= (sy_sum > {1'b0, DIST_INF}) ? DIST_INF : sy_sum[DIST_W-1:0];
        my_r   <= ry_r[RAY_W-1] ? my_r - 1'b1 : my_r + 1'b1;
        side_r <= 1'b1;
      end
    end
    if (cmd.code_ld) begin
      code_r <= map_rdata;
    end
    if (cmd.h_ld) begin
      h_r <= (perp_r == '0 || quo > QUO_W'(HEIGHT_MAX)) ? HEIGHT_MAX : quo[HGT_W-1:0];
    end
    if (cmd.tex_ld) begin
      wf_r <= (side_r ? pos_x_r[15:0] : pos_y_r[15:0]) + tprod[31:16];
    end
  end

  // map store
  assign map_waddr = cmd.map_clr ? cmd.clr_addr : {in_row, in_cc};
  assign map_wdata = cmd.map_clr ? '0 : in_code;
  assign map_raddr = {mx_r[MAP_W-1:0], my_r[MAP_W-1:0]};

  gcast_map u_map (
    .clk   (clk),
    .we    (cmd.map_clr | cmd.map_wr),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // result formatting
  always_comb begin
    tex = wf_r[15 -: TEX_W];
    if ((!side_r && !rx_r[RAY_W-1] && rx_r != '0) || (side_r && ry_r[RAY_W-1])) begin
      tex = ~tex;
    end
    h2 = h_r[HGT_W-1:1];
    if (h2 >= (HGT_W-1)'(ROWS / 2)) begin
      ds = '0;
      de = ROW_W'(ROWS);
    end else begin
      ds = ROW_W'(ROWS / 2) - ROW_W'(h2);
      de = ROW_W'(ROWS / 2) + ROW_W'(h2);
    end
    pd = (perp_r > DIST_W'(PERP_MAX)) ? PERP_MAX : perp_r[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_ld) begin
      out_hit_r <= cmd.hit;
      if (cmd.hit) begin
        out_data_r <= {6'd0, code_r - 1'b1, tex, de, ds, h_r, pd, side_r, col_r};
      end else begin
        out_data_r <= {6'd0, CODE_W'(0), TEX_W'(0), ROW_W'(0), ROW_W'(0),
                       HGT_W'(0), PERP_MAX, 1'b0, col_r};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_hit_r;

  assign sts.in_op    = in_tuser;
  assign sts.col_ok   = in_col < 8'(COLUMNS);
  assign sts.div_done = div_done;
  assign sts.oob      = mx_r < 0 || my_r < 0 ||
                        mx_r >= (MAP_W+2)'(MAP_SIZE) || my_r >= (MAP_W+2)'(MAP_SIZE);
  assign sts.code_nz  = map_rdata != '0;
  assign sts.out_full = out_valid_r;

endmodule

// File: sv/gcast_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcast_ctrl
// sequencer for map clear, map writes and column casts
// ----------------------------------------------------------------------------
module gcast_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output gcast_pkg::cmd_t  cmd,
  input  gcast_pkg::sts_t  sts
);
  import gcast_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RAY, S_DX_GO, S_DX_RUN, S_DY_GO, S_DY_RUN, S_SIDE,
    S_STEP, S_LOOK, S_CHK, S_H_GO, S_H_RUN, S_TEX, S_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic              hit_r, hit_nxt;
  logic              acc;

  assign in_tready = state_r == S_IDLE;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    steps_nxt = steps_r;
    hit_nxt   = hit_r;
    cmd          = '0;
    cmd.clr_addr = clr_r;
    cmd.hit      = hit_r;
    cmd.div_sel  = DIV_HT;
    case (state_r)
      S_CLR: begin
        cmd.map_clr = 1'b1;
        clr_nxt     = clr_r + 1'b1;
        if (clr_r == {ADDR_W{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          if (sts.in_op == OP_WRITE) begin
            cmd.map_wr = 1'b1;
          end else if (sts.col_ok) begin
            cmd.cast_ld = 1'b1;
            state_nxt   = S_RAY;
          end
        end
      end
      S_RAY: begin
        cmd.ray_ld = 1'b1;
        state_nxt  = S_DX_GO;
      end
      S_DX_GO: begin
        cmd.div_sel   = DIV_DX;
        cmd.div_start = 1'b1;
        state_nxt     = S_DX_RUN;
      end
      S_DX_RUN: begin
        if (sts.div_done) begin
          cmd.dx_ld = 1'b1;
          state_nxt = S_DY_GO;
        end
      end
      S_DY_GO: begin
        cmd.div_sel   = DIV_DY;
        cmd.div_start = 1'b1;
        state_nxt     = S_DY_RUN;
      end
      S_DY_RUN: begin
        if (sts.div_done) begin
          cmd.dy_ld = 1'b1;
          state_nxt = S_SIDE;
        end
      end
      S_SIDE: begin
        cmd.side_ld = 1'b1;
        steps_nxt   = '0;
        state_nxt   = S_STEP;
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        steps_nxt = steps_r + 1'b1;
        state_nxt = S_LOOK;
      end
      S_LOOK: begin
        // map read of the entered cell is issued here
        if (sts.oob) begin
          hit_nxt   = 1'b0;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.code_nz) begin
          cmd.code_ld = 1'b1;
          hit_nxt     = 1'b1;
          state_nxt   = S_H_GO;
        end else if (steps_r == STEP_W'(MAX_STEPS)) begin
          hit_nxt   = 1'b0;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_H_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_H_RUN;
      end
      S_H_RUN: begin
        if (sts.div_done) begin
          cmd.h_ld  = 1'b1;
          state_nxt = S_TEX;
        end
      end
      S_TEX: begin
        cmd.tex_ld = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_full) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      steps_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      steps_r <= steps_nxt;
      hit_r   <= hit_nxt;
    end
  end

endmodule

// File: sv/grid_ray_cast_wall_column.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_ray_cast_wall_column
// dda grid ray caster returning one wall stripe per screen column
// ----------------------------------------------------------------------------
// input beats: in_tuser is the op (0 map write, 1 column cast). a write beat
// stores one wall code. a cast beat yields one result beat on the out_
// channel; casts of columns past the screen width give none. out_tuser
// carries the hit flag. a cast that hits runs three serial divides (two
// ray deltas and the stripe height) and a dda walk of at most 64 cells,
// each step waiting on the registered map read. a miss skips the height
// divide. one item is worked at a time. the user must see that camera
// registers are written on the cfg_ channel only while the block is idle;
// the block itself does not enforce it. after reset the map is cleared
// with in_tready low; the config channel is open throughout. a result
// waits in the output register while out_tready is low; the next item is
// still taken, and a further result waits in its final state until the
// register frees.
// ----------------------------------------------------------------------------
module grid_ray_cast_wall_column (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // column[7:0] cell_row[12:8] cell_col[17:13] cell_code[21:18]
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // out_column[7:0] side[8] perp_dist[29:9]
                                  // stripe_height[41:30] draw_start[49:42]
                                  // draw_end[57:50] tex_column[61:58] tex_index[65:62]
  output logic        out_tuser,  // hit
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [20:0] cfg_data
);
  import gcast_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  gcast_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  gcast_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: dv/grid_ray_cast_wall_column_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_ray_cast_wall_column_tb
// self-checking bench for the dda grid ray caster
// ----------------------------------------------------------------------------
// map writes and column casts are streamed in under several camera settings
// and backpressure mixes. a scoreboard class keeps its own map and camera,
// walks every cast ray itself and compares each result beat field by field.
// ----------------------------------------------------------------------------
module grid_ray_cast_wall_column_tb;
  import gcast_pkg::*;

  localparam int IDLE_LIMIT = 6000;
  localparam int SETTLE     = 400;

  typedef struct {
    bit [7:0]  column;
    bit        hit;
    bit        side;
    bit [20:0] perp;
    bit [11:0] height;
    bit [7:0]  draw_start;
    bit [7:0]  draw_end;
    bit [3:0]  tex_col;
    bit [3:0]  tex_idx;
  } stripe_t;

  class column_scoreboard;
    bit [20:0]        pos_x, pos_y;
    bit signed [17:0] dir_x, dir_y, plane_x, plane_y;
    bit [3:0]         wall_map [MAP_SIZE*MAP_SIZE];
    stripe_t          stripe_q[$];
    int               errors;

    function new();
      pos_x = 0; pos_y = 0;
      dir_x = -18'sd65536; dir_y = 0;
      plane_x = 0; plane_y = 18'sd43254;
      foreach (wall_map[i]) wall_map[i] = 0;
      errors = 0;
    endfunction

    function void set_reg(bit [2:0] idx, bit [20:0] val);
      case (idx)
        REG_POS_X:   pos_x = val;
        REG_POS_Y:   pos_y = val;
        REG_DIR_X:   dir_x = val[17:0];
        REG_DIR_Y:   dir_y = val[17:0];
        REG_PLANE_X: plane_x = val[17:0];
        REG_PLANE_Y: plane_y = val[17:0];
        default: ;
      endcase
    endfunction

    function bit [63:0] ray_delta(longint r);
      if (r == 0) return DIST_INF;
      return (64'd1 << 32) / 64'(r < 0 ? -r : r);
    endfunction

    // distance along the ray to the first grid line
    function bit [63:0] first_side(bit [20:0] p, longint r, bit [63:0] d);
      bit [63:0] f;
      f = (r < 0) ? 64'(p[15:0]) : 64'd65536 - 64'(p[15:0]);
      if (d == DIST_INF) return DIST_INF;
      return (f * d) >> 16;
    endfunction

    function bit [63:0] sat_sum(bit [63:0] a, bit [63:0] b);
      bit [63:0] s;
      s = a + b;
      return (s > DIST_INF) ? DIST_INF : s;
    endfunction

    function bit pending();
      return stripe_q.size() != 0;
    endfunction

    function void note_item(bit op, bit [7:0] col, bit [4:0] row, bit [4:0] ccol,
                            bit [3:0] code);
      longint    cam, rx, ry, mx, my;
      bit [63:0] dx, dy, sx, sy, perp, h, wx;
      bit        side, hit;
      bit [3:0]  wall_code, tex;
      stripe_t   s;
      if (op == OP_WRITE) begin
        wall_map[int'(row)*MAP_SIZE + int'(ccol)] = code;
        return;
      end
      if (col >= COLUMNS) return;
      cam = (longint'(col) * 131072) / COLUMNS - 65536;
      rx = longint'(dir_x) + ((longint'(plane_x) * cam) >>> 16);
      ry = longint'(dir_y) + ((longint'(plane_y) * cam) >>> 16);
      mx = pos_x >> 16;
      my = pos_y >> 16;
      dx = ray_delta(rx);
      dy = ray_delta(ry);
      sx = first_side(pos_x, rx, dx);
      sy = first_side(pos_y, ry, dy);
      perp = 0; side = 0; hit = 0; wall_code = 0;
      for (int n = 0; n < MAX_STEPS; n++) begin
        if (sx < sy) begin
          perp = sx; sx = sat_sum(sx, dx); mx += (rx < 0) ? -1 : 1; side = 0;
        end else begin
          perp = sy; sy = sat_sum(sy, dy); my += (ry < 0) ? -1 : 1; side = 1;
        end
        if (mx < 0 || my < 0 || mx >= MAP_SIZE || my >= MAP_SIZE) break;
        wall_code = wall_map[mx*MAP_SIZE + my];
        if (wall_code != 0) begin
          hit = 1;
          break;
        end
      end
      s = '{column: col, hit: 0, side: 0, perp: PERP_MAX, height: 0,
            draw_start: 0, draw_end: 0, tex_col: 0, tex_idx: 0};
      if (hit) begin
        h = (perp == 0) ? 64'(HEIGHT_MAX) : (64'(ROWS) << 16) / perp;
        if (h > HEIGHT_MAX) h = HEIGHT_MAX;
        wx = side ? 64'(pos_x) + ((perp * 64'(rx)) >> 16)
                  : 64'(pos_y) + ((perp * 64'(ry)) >> 16);
        tex = wx[15:12];
        if ((!side && rx > 0) || (side && ry < 0)) tex = 4'(TEX_SIZE - 1) - tex;
        s.hit = 1;
        s.side = side;
        s.perp = (perp > PERP_MAX) ? PERP_MAX : perp[20:0];
        s.height = h[11:0];
        s.draw_start = (h / 2 >= ROWS / 2) ? 8'd0 : 8'(ROWS / 2 - h / 2);
        s.draw_end = (ROWS / 2 + h / 2 > ROWS) ? 8'(ROWS) : 8'(ROWS / 2 + h / 2);
        s.tex_col = tex;
        s.tex_idx = wall_code - 4'd1;
      end
      stripe_q.push_back(s);
    endfunction

    function void compare(string name, bit [31:0] exp_v, bit [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_stripe(bit [71:0] d, bit hit);
      stripe_t e;
      if (stripe_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result beat: expected none actual %h", $time, d);
        return;
      end
      e = stripe_q.pop_front();
      compare("out_column", e.column, d[7:0]);
      compare("hit", e.hit, hit);
      compare("side", e.side, d[8]);
      compare("perp_dist", e.perp, d[29:9]);
      compare("stripe_height", e.height, d[41:30]);
      compare("draw_start", e.draw_start, d[49:42]);
      compare("draw_end", e.draw_end, d[57:50]);
      compare("tex_column", e.tex_col, d[61:58]);
      compare("tex_index", e.tex_idx, d[65:62]);
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // column[7:0] cell_row[12:8] cell_col[17:13] cell_code[21:18]
  logic        in_tuser = 0;    // op
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [71:0] out_tdata;       // out_column side perp_dist stripe_height draw_start
                                // draw_end tex_column tex_index
  logic        out_tuser;       // hit
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [20:0] cfg_data = '0;

  column_scoreboard sb = new;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cnt = 0;

  grid_ray_cast_wall_column dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_stripe(out_tdata, out_tuser);
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cnt <= 0;
    else if (idle_cnt == IDLE_LIMIT) begin
      $display("%0t watchdog expired", $time);
      $display("[FAIL] regression broken");
      $finish;
    end else
      idle_cnt <= idle_cnt + 1;
  end

  task automatic send_item(bit op, bit [7:0] col, bit [4:0] row, bit [4:0] ccol,
                           bit [3:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {2'b00, code, ccol, row, col};
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, col, row, ccol, code);
  endtask

  task automatic write_cell(int row, int ccol, int code);
    send_item(OP_WRITE, 8'($urandom), 5'(row), 5'(ccol), 4'(code));
  endtask

  task automatic cast(int col);
    send_item(OP_CAST, 8'(col), 5'($urandom), 5'($urandom), 4'($urandom));
  endtask

  task automatic cfg_write(bit [2:0] idx, bit [20:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic set_camera(int px, int py, int dx, int dy, int plx, int ply);
    cfg_write(REG_POS_X, 21'(px));
    cfg_write(REG_POS_Y, 21'(py));
    cfg_write(REG_DIR_X, 21'(dx));
    cfg_write(REG_DIR_Y, 21'(dy));
    cfg_write(REG_PLANE_X, 21'(plx));
    cfg_write(REG_PLANE_Y, 21'(ply));
  endtask

  // waits until every expected result beat is checked, then lets the block finish a write that has no result beat
  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending()) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic int rand_vec();
    return $urandom_range(262143) - 131072;
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;

    // directed: camera mid-map looking down -x
    set_camera(16 * 65536 + 32768, 16 * 65536 + 32768, -65536, 0, 0, 43254);
    cfg_write(3'd6, 21'h1fffff);
    cfg_write(3'd7, 21'h0);
    cast(0);
    write_cell(10, 16, 1);
    write_cell(10, 15, 15);
    write_cell(10, 17, 7);
    write_cell(20, 16, 2);
    write_cell(16, 10, 3);
    write_cell(16, 31, 4);
    write_cell(0, 0, 5);
    write_cell(31, 31, 15);
    cast(0);
    cast(79);
    cast(80);
    cast(159);
    cast(160);
    cast(255);
    write_cell(10, 16, 0);
    cast(80);
    cast(128);
    cast(1);
    drain();

    for (int k = 0; k < 8; k++) begin
      case (k / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      case (k)
        0: set_camera(16 * 65536 + 32768, 16 * 65536 + 32768, 65536, 0, 0, -43254);
        1: set_camera(0, 0, 131071, 131071, -131072, 131071);
        2: set_camera(2097151, 2097151, -131072, -131072, 131071, -131072);
        // ray y is zero and the camera sits on grid lines
        3: set_camera(16 * 65536, 12 * 65536, -65536, 0, 43254, 0);
        default: set_camera($urandom_range(2097151), $urandom_range(2097151),
                            rand_vec(), rand_vec(), rand_vec(), rand_vec());
      endcase
      for (int i = 0; i < 56; i++) begin
        if (k == 4 && i == 28) drain();
        if ($urandom_range(99) < 30)
          write_cell($urandom_range(31), $urandom_range(31),
                     ($urandom_range(3) == 0) ? 0 : $urandom_range(15));
        else if ($urandom_range(19) == 0)
          cast($urandom_range(255, 160));
        else
          cast($urandom_range(159));
      end
      drain();
    end

    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// File: filelist.f
sv/gcast_pkg.sv
sv/gcast_div.sv
sv/gcast_map.sv
sv/gcast_dp.sv
sv/gcast_ctrl.sv
sv/grid_ray_cast_wall_column.sv
dv/grid_ray_cast_wall_column_tb.sv
